FILE: hdl/dcad_pkg.sv
`default_nettype none
package dcad_pkg;

   // Default sizes of the channel table.
   localparam int CHANNELS       = 16;
   localparam int REQ_BITS       = 8;
   localparam int HANDLER_BITS   = 8;
   // Depth of the queue between front and back; a power of two, at least 2.
   localparam int QUEUE_DEPTH    = 2;
   // Dispatch services at most this many low interrupt lines.
   localparam int DISPATCH_LINES = 16;

   // Fixed widths of the item fields at the ports.
   localparam int FUNC_BITS     = 3;
   localparam int REQ_PORT_BITS = 8;
   localparam int HND_PORT_BITS = 8;
   localparam int CH_PORT_BITS  = 4;
   localparam int IRQ_BITS      = 32;
   localparam int STATUS_BITS   = 2;

   typedef enum logic [FUNC_BITS-1:0] {
      OP_ALLOC    = 3'd0,
      OP_LOOKUP   = 3'd1,
      OP_FREE     = 3'd2,
      OP_CLEAR    = 3'd3,
      OP_DISPATCH = 3'd4
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK     = 2'd0,
      ST_MISS   = 2'd1,
      ST_NO_IRQ = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_EXEC,
      BK_SCAN
   } back_state_type;

   typedef struct packed {
      status_type                status;
      logic [CH_PORT_BITS-1:0]   channel;
      logic [HND_PORT_BITS-1:0]  handler;
      logic [IRQ_BITS-1:0]       ack_bits;
      logic                      last;
   } rsp_type;

endpackage
`default_nettype wire

FILE: hdl/dcad_front.sv
`default_nettype none
module dcad_front #(
   parameter int REQ_BITS     = dcad_pkg::REQ_BITS,
   parameter int HANDLER_BITS = dcad_pkg::HANDLER_BITS,
   parameter int DATA_BITS    = dcad_pkg::FUNC_BITS + REQ_BITS + HANDLER_BITS
                                + dcad_pkg::CH_PORT_BITS + dcad_pkg::IRQ_BITS
) (
   input  wire logic                               accept,
   input  wire logic [dcad_pkg::FUNC_BITS-1:0]     req_func,
   input  wire logic [dcad_pkg::REQ_PORT_BITS-1:0] req_requestor,
   input  wire logic [dcad_pkg::HND_PORT_BITS-1:0] req_handler_id,
   input  wire logic [dcad_pkg::CH_PORT_BITS-1:0]  req_channel,
   input  wire logic [dcad_pkg::IRQ_BITS-1:0]      req_pending,
   input  wire logic [dcad_pkg::IRQ_BITS-1:0]      req_mask,
   output logic                                    push,
   output logic [DATA_BITS-1:0]                    push_data
);

   logic                   known_op;
   logic [REQ_BITS-1:0]    req_key;
   logic [HANDLER_BITS-1:0] hnd_key;
   logic [dcad_pkg::IRQ_BITS-1:0] irq;

   always_comb begin
      unique case (req_func)
         dcad_pkg::OP_ALLOC,
         dcad_pkg::OP_LOOKUP,
         dcad_pkg::OP_FREE,
         dcad_pkg::OP_CLEAR,
         dcad_pkg::OP_DISPATCH: known_op = 1'b1;
         default:               known_op = 1'b0;
      endcase
   end

   // Requestor and handler are kept only in their low bits; unknown functions
   // are dropped here and never reach the queue.
   assign req_key   = REQ_BITS'(req_requestor);
   assign hnd_key   = HANDLER_BITS'(req_handler_id);
   assign irq       = req_pending & ~req_mask;
   assign push      = accept && known_op;
   assign push_data = {req_func, req_key, hnd_key, req_channel, irq};

endmodule
`default_nettype wire

FILE: hdl/dcad_queue.sv
`default_nettype none
module dcad_queue #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = dcad_pkg::QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire logic [DATA_BITS-1:0] push_data,
   input  wire logic                 pop,
   output logic [DATA_BITS-1:0]      pop_data,
   output logic                      full,
   output logic                      empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0] slot_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/dcad_back.sv
`default_nettype none
module dcad_back #(
   parameter int CHANNELS     = dcad_pkg::CHANNELS,
   parameter int REQ_BITS     = dcad_pkg::REQ_BITS,
   parameter int HANDLER_BITS = dcad_pkg::HANDLER_BITS,
   parameter int DATA_BITS    = dcad_pkg::FUNC_BITS + REQ_BITS + HANDLER_BITS
                                + dcad_pkg::CH_PORT_BITS + dcad_pkg::IRQ_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_empty,
   input  wire logic [DATA_BITS-1:0] q_data,
   output logic                      q_pop,
   output logic                      rsp_valid,
   output dcad_pkg::rsp_type         rsp
);

   localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int LINES     = (CHANNELS < dcad_pkg::DISPATCH_LINES) ?
                              CHANNELS : dcad_pkg::DISPATCH_LINES;
   localparam int IRQ_LSB   = 0;
   localparam int CH_LSB    = IRQ_LSB + dcad_pkg::IRQ_BITS;
   localparam int HND_LSB   = CH_LSB + dcad_pkg::CH_PORT_BITS;
   localparam int REQ_LSB   = HND_LSB + HANDLER_BITS;
   localparam int OP_LSB    = REQ_LSB + REQ_BITS;

   // Channel table.
   logic [CHANNELS-1:0]     valid_ff, valid_in;
   logic [REQ_BITS-1:0]     req_tab_ff [CHANNELS];
   logic [HANDLER_BITS-1:0] hnd_tab_ff [CHANNELS];
   logic [CHANNELS-1:0]     tbl_set, tbl_clr;

   // Item being carried out.
   dcad_pkg::op_type              w_op_ff, w_op_in;
   logic [REQ_BITS-1:0]           w_req_ff, w_req_in;
   logic [HANDLER_BITS-1:0]       w_hnd_ff, w_hnd_in;
   logic [dcad_pkg::CH_PORT_BITS-1:0] w_ch_ff, w_ch_in;
   logic [dcad_pkg::IRQ_BITS-1:0] w_irq_ff, w_irq_in;
   logic [CHANNELS-1:0]           remain_ff, remain_in;

   dcad_pkg::back_state_type state_ff, state_in;
   dcad_pkg::rsp_type        rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [CHANNELS-1:0] match, vacant, serve, lowest;
   logic [CH_BITS-1:0]  match_idx, vacant_idx, serve_idx;

   function automatic logic [CH_BITS-1:0] first_idx(input logic [CHANNELS-1:0] v);
      logic [CH_BITS-1:0] idx;
      logic               hit;
      idx = '0;
      hit = 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (v[i] && !hit) begin
            idx = CH_BITS'(i);
            hit = 1'b1;
         end
      end
      return idx;
   endfunction

   function automatic logic [dcad_pkg::CH_PORT_BITS-1:0] rsp_ch(
      input logic [CH_BITS-1:0] idx);
      logic [31:0] w;
      w = 32'(idx);
      return w[dcad_pkg::CH_PORT_BITS-1:0];
   endfunction

   function automatic logic [dcad_pkg::HND_PORT_BITS-1:0] rsp_hnd(
      input logic [HANDLER_BITS-1:0] h);
      logic [31:0] w;
      w = 32'(h);
      return w[dcad_pkg::HND_PORT_BITS-1:0];
   endfunction

   // Parallel compares over the whole table.
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         match[i]  = valid_ff[i] && (req_tab_ff[i] == w_req_ff);
         vacant[i] = !valid_ff[i];
         // Only the low lines are serviced, and only valid entries with a nonzero handler.
         serve[i]  = (i < LINES) && w_irq_ff[i] && valid_ff[i] && (hnd_tab_ff[i] != '0);
      end
   end

   assign match_idx  = first_idx(match);
   assign vacant_idx = first_idx(vacant);
   assign serve_idx  = first_idx((state_ff == dcad_pkg::BK_SCAN) ? remain_ff : serve);
   assign lowest     = ((state_ff == dcad_pkg::BK_SCAN) ? remain_ff : serve)
                       & (~((state_ff == dcad_pkg::BK_SCAN) ? remain_ff : serve)
                          + CHANNELS'(1));

   always_comb begin
      state_in     = state_ff;
      w_op_in      = w_op_ff;
      w_req_in     = w_req_ff;
      w_hnd_in     = w_hnd_ff;
      w_ch_in      = w_ch_ff;
      w_irq_in     = w_irq_ff;
      remain_in    = remain_ff;
      q_pop        = 1'b0;
      tbl_set      = '0;
      tbl_clr      = '0;
      rsp_valid_in = 1'b0;
      rsp_in       = '{status: dcad_pkg::ST_OK, channel: '0, handler: '0,
                       ack_bits: '0, last: 1'b1};

      unique case (state_ff)
         dcad_pkg::BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               w_op_in  = dcad_pkg::op_type'(q_data[OP_LSB +: dcad_pkg::FUNC_BITS]);
               w_req_in = q_data[REQ_LSB +: REQ_BITS];
               w_hnd_in = q_data[HND_LSB +: HANDLER_BITS];
               w_ch_in  = q_data[CH_LSB +: dcad_pkg::CH_PORT_BITS];
               w_irq_in = q_data[IRQ_LSB +: dcad_pkg::IRQ_BITS];
               state_in = dcad_pkg::BK_EXEC;
            end
         end

         dcad_pkg::BK_EXEC: begin
            rsp_valid_in = 1'b1;
            state_in     = dcad_pkg::BK_IDLE;
            unique case (w_op_ff)
               dcad_pkg::OP_ALLOC: begin
                  // A requestor that holds a channel gets it back untouched.
                  if (match != '0) begin
                     rsp_in.channel = rsp_ch(match_idx);
                  end else if (vacant != '0) begin
                     rsp_in.channel = rsp_ch(vacant_idx);
                     tbl_set        = vacant & (~vacant + CHANNELS'(1));
                  end else begin
                     rsp_in.status = dcad_pkg::ST_MISS;
                  end
               end
               dcad_pkg::OP_LOOKUP: begin
                  if (match != '0) begin
                     rsp_in.channel = rsp_ch(match_idx);
                  end else begin
                     rsp_in.status = dcad_pkg::ST_MISS;
                  end
               end
               dcad_pkg::OP_FREE: begin
                  if (match != '0) begin
                     rsp_in.channel = rsp_ch(match_idx);
                     tbl_clr        = match & (~match + CHANNELS'(1));
                  end else begin
                     rsp_in.status = dcad_pkg::ST_MISS;
                  end
               end
               dcad_pkg::OP_CLEAR: begin
                  rsp_in.channel = w_ch_ff;
                  if (32'(w_ch_ff) < 32'(CHANNELS)) begin
                     for (int i = 0; i < CHANNELS; i++) begin
                        tbl_clr[i] = (32'(w_ch_ff) == 32'(i));
                     end
                  end else begin
                     rsp_in.status = dcad_pkg::ST_MISS;
                  end
               end
               dcad_pkg::OP_DISPATCH: begin
                  if (w_irq_ff == '0) begin
                     rsp_in.status = dcad_pkg::ST_NO_IRQ;
                  end else if (serve == '0) begin
                     rsp_in.ack_bits = w_irq_ff;
                  end else begin
                     rsp_in.channel  = rsp_ch(serve_idx);
                     rsp_in.handler  = rsp_hnd(hnd_tab_ff[serve_idx]);
                     rsp_in.ack_bits = w_irq_ff;
                     remain_in       = serve & ~lowest;
                     rsp_in.last     = (remain_in == '0);
                     if (remain_in != '0) begin
                        state_in = dcad_pkg::BK_SCAN;
                     end
                  end
               end
               default: begin
                  rsp_valid_in = 1'b0;
               end
            endcase
         end

         dcad_pkg::BK_SCAN: begin
            rsp_valid_in    = 1'b1;
            rsp_in.channel  = rsp_ch(serve_idx);
            rsp_in.handler  = rsp_hnd(hnd_tab_ff[serve_idx]);
            rsp_in.ack_bits = w_irq_ff;
            remain_in       = remain_ff & ~lowest;
            rsp_in.last     = (remain_in == '0);
            if (remain_in == '0) begin
               state_in = dcad_pkg::BK_IDLE;
            end
         end

         default: begin
            state_in = dcad_pkg::BK_IDLE;
         end
      endcase

      valid_in = (valid_ff & ~tbl_clr) | tbl_set;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dcad_pkg::BK_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         remain_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         remain_ff    <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      w_op_ff  <= w_op_in;
      w_req_ff <= w_req_in;
      w_hnd_ff <= w_hnd_in;
      w_ch_ff  <= w_ch_in;
      w_irq_ff <= w_irq_in;
      rsp_ff   <= rsp_in;
      for (int i = 0; i < CHANNELS; i++) begin
         if (tbl_set[i]) begin
            req_tab_ff[i] <= w_req_ff;
            hnd_tab_ff[i] <= w_hnd_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_scan_has_work: assert property (@(posedge clock) disable iff (reset)
      state_ff == dcad_pkg::BK_SCAN |-> remain_ff != '0)
      else $error("dispatch scan running with nothing left to service");

   a_not_last_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last |-> state_ff == dcad_pkg::BK_SCAN)
      else $error("non-final result without a dispatch scan behind it");

   a_no_irq_no_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == dcad_pkg::ST_NO_IRQ |->
         rsp_ff.ack_bits == '0 && rsp_ff.last)
      else $error("no-interrupt result carries acknowledge bits");

   a_table_stable_in_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == dcad_pkg::BK_SCAN |=> $stable(valid_ff))
      else $error("channel table changed during a dispatch scan");

endmodule
`default_nettype wire

FILE: hdl/dma_channel_allocator_dispatch.sv
`default_nettype none
// Channel    Direction  Handshake                       Fields
// request    in         start && !busy accepts an item  req_func, req_requestor,
//                                                       req_handler_id, req_channel,
//                                                       req_pending, req_mask
// response   out        rsp_valid, no back-pressure       rsp_status, rsp_result_channel,
//                                                       rsp_result_handler, rsp_ack_bits,
//                                                       rsp_last
//
// Items go into a QUEUE_DEPTH-deep queue; busy is high while that queue is full.
// The back end takes an item from the queue while idle, then searches and updates the
// table; a dispatch that services N channels gives N results, one per channel. It takes
// no new item from the queue until it is through with the current one.
// Synchronous reset frees every channel and empties the queue.
// Results cannot be stalled: each is shown for exactly one cycle.
module dma_channel_allocator_dispatch #(
   parameter int CHANNELS     = dcad_pkg::CHANNELS,
   parameter int REQ_BITS     = dcad_pkg::REQ_BITS,
   parameter int HANDLER_BITS = dcad_pkg::HANDLER_BITS,
   parameter int QUEUE_DEPTH  = dcad_pkg::QUEUE_DEPTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [dcad_pkg::FUNC_BITS-1:0]     req_func,
   input  wire logic [dcad_pkg::REQ_PORT_BITS-1:0] req_requestor,
   input  wire logic [dcad_pkg::HND_PORT_BITS-1:0] req_handler_id,
   input  wire logic [dcad_pkg::CH_PORT_BITS-1:0]  req_channel,
   input  wire logic [dcad_pkg::IRQ_BITS-1:0]      req_pending,
   input  wire logic [dcad_pkg::IRQ_BITS-1:0]      req_mask,
   output logic                                    rsp_valid,
   output logic [dcad_pkg::STATUS_BITS-1:0]        rsp_status,
   output logic [dcad_pkg::CH_PORT_BITS-1:0]       rsp_result_channel,
   output logic [dcad_pkg::HND_PORT_BITS-1:0]      rsp_result_handler,
   output logic [dcad_pkg::IRQ_BITS-1:0]           rsp_ack_bits,
   output logic                                    rsp_last
);

   localparam int DATA_BITS = dcad_pkg::FUNC_BITS + REQ_BITS + HANDLER_BITS
                              + dcad_pkg::CH_PORT_BITS + dcad_pkg::IRQ_BITS;

   logic                 accept;
   logic                 push, pop, q_full, q_empty;
   logic [DATA_BITS-1:0] push_data, pop_data;
   dcad_pkg::rsp_type    rsp;

   assign busy   = q_full;
   assign accept = start && !q_full;

   dcad_front #(
      .REQ_BITS     (REQ_BITS),
      .HANDLER_BITS (HANDLER_BITS),
      .DATA_BITS    (DATA_BITS)
   ) u_front (
      .accept         (accept),
      .req_func       (req_func),
      .req_requestor  (req_requestor),
      .req_handler_id (req_handler_id),
      .req_channel    (req_channel),
      .req_pending    (req_pending),
      .req_mask       (req_mask),
      .push           (push),
      .push_data      (push_data)
   );

   dcad_queue #(
      .DATA_BITS (DATA_BITS),
      .DEPTH     (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   dcad_back #(
      .CHANNELS     (CHANNELS),
      .REQ_BITS     (REQ_BITS),
      .HANDLER_BITS (HANDLER_BITS),
      .DATA_BITS    (DATA_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (pop_data),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_status         = rsp.status;
   assign rsp_result_channel = rsp.channel;
   assign rsp_result_handler = rsp.handler;
   assign rsp_ack_bits       = rsp.ack_bits;
   assign rsp_last           = rsp.last;

endmodule
`default_nettype wire
